/* src/p2dma_pkg.sv */
// ----------------------------------------------------------------------------
// p2dma_pkg
// Shared constants and types of the 2-D max / average pooling core.
// ----------------------------------------------------------------------------
package p2dma_pkg;

  localparam int DEF_MAX_KERNEL  = 4;
  localparam int DEF_MAX_WIDTH   = 256;
  localparam int DEF_SAMPLE_BITS = 16;

  // Divisor covers stride (up to 7) and window area (up to 7 * 7).
  localparam int DIVISOR_BITS  = 6;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 11;
  localparam int CHAN_BITS     = 10;
  localparam int ROW_BITS      = 10;
  localparam int OCOL_BITS     = 8;
  localparam int HGT_BITS      = 11;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_POOL_MODE   = 3'd0,
    CFG_KERNEL_SIZE = 3'd1,
    CFG_STRIDE      = 3'd2,
    CFG_MAP_HEIGHT  = 3'd3,
    CFG_MAP_WIDTH   = 3'd4,
    CFG_CHANNELS    = 3'd5
  } cfg_idx_e;

endpackage

/* src/pool_2d_max_avg_core.sv */
// ----------------------------------------------------------------------------
// pool_2d_max_avg_core
// Streamed 2-D max / average pooling with a row ring in block memory.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+---------------------------------
//  input    | in_valid_i / in_stall_o   | sample_i
//  output   | out_valid_o / out_stall_i | pooled_value_o, out_channel_o,
//           |                           | out_row_o, out_col_o, last_o
//  config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A sample that is no window corner needs no work beyond its ring write; one
// that fails the stride phase check on row or column returns to idle after
// that divider run. A window takes 2 divider runs, k*k ring reads plus a drain
// step, a finish step, and in average mode one more divider run before emit.
// The serial divider is shared by all these runs. Reset clears counters and
// loads the default configuration; the ring needs no clearing. A stalled
// output holds its beat while the next sample is processed up to its own emit.
// ----------------------------------------------------------------------------
module pool_2d_max_avg_core #(
  parameter int MAX_KERNEL  = p2dma_pkg::DEF_MAX_KERNEL,
  parameter int MAX_WIDTH   = p2dma_pkg::DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = p2dma_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [p2dma_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [p2dma_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]         sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]         pooled_value_o,
  output logic [p2dma_pkg::CHAN_BITS-1:0]       out_channel_o,
  output logic [p2dma_pkg::ROW_BITS-1:0]        out_row_o,
  output logic [p2dma_pkg::OCOL_BITS-1:0]       out_col_o,
  output logic                                  last_o
);

  localparam int SB    = SAMPLE_BITS;
  localparam int DVW   = p2dma_pkg::DIVISOR_BITS;
  localparam int SUMW  = SB + DVW;
  localparam int DW    = SUMW;
  localparam int DEPTH = MAX_KERNEL * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = (CW + 1 > 9) ? CW + 1 : 9;
  localparam int WX    = WW + 1;
  localparam int RSW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int TW    = RSW + 4;
  localparam int HW    = p2dma_pkg::HGT_BITS;
  localparam int CHW   = p2dma_pkg::CHAN_BITS;
  localparam int RW    = p2dma_pkg::ROW_BITS;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DROW  = 8'b0000_0010,
    ST_DCOL  = 8'b0000_0100,
    ST_READ  = 8'b0000_1000,
    ST_DRAIN = 8'b0001_0000,
    ST_FIN   = 8'b0010_0000,
    ST_DAVG  = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic           mode_q;
  logic [2:0]     kernel_q, stride_q;
  logic [HW-1:0]  height_q, chans_q;
  logic [8:0]     width_q;

  // position counters
  logic [CW-1:0]  col_q;
  logic [RW-1:0]  row_q;
  logic [CHW-1:0] chan_q;
  logic [RSW-1:0] rslot_q;

  // per-window context
  logic [CW-1:0]  w0_q, rc_q;
  logic [RSW-1:0] top_q, rr_q;
  logic [CHW-1:0] wch_q;
  logic           wlast_q;
  logic [2:0]     i_q, j_q;
  logic [RW-1:0]  orow_q;
  logic [p2dma_pkg::OCOL_BITS-1:0] ocol_q;
  logic           rd_vld_q, first_q, neg_q;
  logic signed [SB-1:0]   best_q, res_q;
  logic signed [SUMW-1:0] sum_q;

  // output register
  logic           ovld_q;
  logic signed [SB-1:0] oval_q;
  logic [CHW-1:0] och_q;
  logic [RW-1:0]  oorow_q;
  logic [p2dma_pkg::OCOL_BITS-1:0] oocol_q;
  logic           olast_q;

  logic [3:0]     k;
  logic [2:0]     s;
  logic [HW-1:0]  hgt, chn;
  logic [WW-1:0]  wid, wx;
  logic           accept, cand, wlast, row_end, col_end;
  logic [HW-1:0]  h0;
  logic [WW-1:0]  w0;
  logic [TW-1:0]  top_sum;
  logic [RSW-1:0] top;
  logic [2:0]     km1;
  logic           rd_en, out_load;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [SB-1:0]  rd_data;
  logic signed [SB-1:0] rdv;

  logic           div_start, div_busy, div_done;
  logic [DW-1:0]  div_dividend, div_quot;
  logic [DVW-1:0] div_divisor, div_rem;
  logic [SUMW-1:0] sum_abs;
  logic [SB-1:0]  qtr;

  // effective geometry
  always_comb begin
    if (kernel_q == 3'd0) begin
      k = 4'd1;
    end else if ({1'b0, kernel_q} > 4'(MAX_KERNEL)) begin
      k = 4'(MAX_KERNEL);
    end else begin
      k = {1'b0, kernel_q};
    end
    s   = (stride_q == 3'd0) ? 3'd1 : stride_q;
    hgt = (height_q == '0) ? HW'(1) : (height_q > HW'(1024)) ? HW'(1024) : height_q;
    chn = (chans_q == '0) ? HW'(1) : (chans_q > HW'(1024)) ? HW'(1024) : chans_q;
    wx  = WW'(width_q);
    wid = (width_q == '0) ? WW'(1) : (wx > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : wx;
  end

  assign km1     = 3'(k - 4'd1);
  assign accept  = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign cand = (HW'(row_q) < hgt) && (WW'(col_q) < wid) &&
                (HW'(row_q) + HW'(1) >= HW'(k)) && (WW'(col_q) + WW'(1) >= WW'(k));
  assign h0   = HW'(row_q) + HW'(1) - HW'(k);
  assign w0   = WW'(col_q) + WW'(1) - WW'(k);
  assign wlast = (HW'(chan_q) + HW'(1) >= chn) &&
                 (12'(h0) + 12'(s) + 12'(k) > 12'(hgt)) &&
                 (WX'(w0) + WX'(s) + WX'(k) > WX'(wid));
  assign col_end = WW'(col_q) + WW'(1) >= wid;
  assign row_end = HW'(row_q) + HW'(1) >= hgt;

  assign top_sum = TW'(rslot_q) + TW'(MAX_KERNEL) - TW'(km1);
  assign top     = (top_sum >= TW'(MAX_KERNEL)) ? RSW'(top_sum - TW'(MAX_KERNEL))
                                                : RSW'(top_sum);

  assign wr_addr = AW'(rslot_q) * AW'(MAX_WIDTH) + AW'(col_q);
  assign rd_addr = AW'(rr_q) * AW'(MAX_WIDTH) + AW'(rc_q);
  assign rd_en   = (state_q == ST_READ);
  assign rdv     = $signed(rd_data);

  assign out_load = (state_q == ST_EMIT) && (!ovld_q || !out_stall_i);

  // divider requests
  assign sum_abs = sum_q[SUMW-1] ? $unsigned(-sum_q) : $unsigned(sum_q);
  assign qtr     = div_quot[SB-1:0];
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DW'(h0);
    div_divisor  = DVW'(s);
    unique case (state_q)
      ST_IDLE: begin
        div_start = accept && cand;
      end
      ST_DROW: begin
        div_start    = div_done && (div_rem == '0);
        div_dividend = DW'(w0_q);
      end
      ST_FIN: begin
        div_start    = mode_q;
        div_dividend = DW'(sum_abs);
        div_divisor  = DVW'(k) * DVW'(k);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept && cand) state_d = ST_DROW;
      ST_DROW:  if (div_done) state_d = (div_rem == '0) ? ST_DCOL : ST_IDLE;
      ST_DCOL:  if (div_done) state_d = (div_rem == '0) ? ST_READ : ST_IDLE;
      ST_READ:  if (i_q == km1 && j_q == km1) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_FIN;
      ST_FIN:   state_d = mode_q ? ST_DAVG : ST_EMIT;
      ST_DAVG:  if (div_done) state_d = ST_EMIT;
      ST_EMIT:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mode_q   <= 1'b0;
      kernel_q <= 3'd2;
      stride_q <= 3'd2;
      height_q <= HW'(1);
      width_q  <= 9'd1;
      chans_q  <= HW'(1);
      col_q    <= '0;
      row_q    <= '0;
      chan_q   <= '0;
      rslot_q  <= '0;
      rd_vld_q <= 1'b0;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          p2dma_pkg::CFG_POOL_MODE:   mode_q   <= cfg_data_i[0];
          p2dma_pkg::CFG_KERNEL_SIZE: kernel_q <= cfg_data_i[2:0];
          p2dma_pkg::CFG_STRIDE:      stride_q <= cfg_data_i[2:0];
          p2dma_pkg::CFG_MAP_HEIGHT:  height_q <= cfg_data_i;
          p2dma_pkg::CFG_MAP_WIDTH:   width_q  <= cfg_data_i[8:0];
          p2dma_pkg::CFG_CHANNELS:    chans_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        if (col_end) begin
          col_q <= '0;
          if (row_end) begin
            row_q   <= '0;
            rslot_q <= '0;
            chan_q  <= (HW'(chan_q) + HW'(1) >= chn) ? '0 : chan_q + 1'b1;
          end else begin
            row_q   <= row_q + 1'b1;
            rslot_q <= (rslot_q == RSW'(MAX_KERNEL - 1)) ? '0 : rslot_q + 1'b1;
          end
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      if (out_load) begin
        ovld_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  // window datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      w0_q    <= CW'(w0);
      top_q   <= top;
      wch_q   <= chan_q;
      wlast_q <= wlast;
    end
    if (state_q == ST_DROW && div_done) begin
      orow_q <= RW'(div_quot);
    end
    if (state_q == ST_DCOL && div_done) begin
      ocol_q  <= div_quot[p2dma_pkg::OCOL_BITS-1:0];
      i_q     <= '0;
      j_q     <= '0;
      rr_q    <= top_q;
      rc_q    <= w0_q;
      first_q <= 1'b1;
    end
    if (state_q == ST_READ) begin
      if (j_q == km1) begin
        j_q  <= '0;
        i_q  <= i_q + 1'b1;
        rc_q <= w0_q;
        rr_q <= (rr_q == RSW'(MAX_KERNEL - 1)) ? '0 : rr_q + 1'b1;
      end else begin
        j_q  <= j_q + 1'b1;
        rc_q <= rc_q + 1'b1;
      end
    end
    if (rd_vld_q) begin
      first_q <= 1'b0;
      if (first_q) begin
        best_q <= rdv;
        sum_q  <= SUMW'(rdv);
      end else begin
        if (rdv > best_q) best_q <= rdv;
        sum_q <= sum_q + SUMW'(rdv);
      end
    end
    if (state_q == ST_FIN) begin
      neg_q <= sum_q[SUMW-1];
      res_q <= best_q;
    end
    if (state_q == ST_DAVG && div_done) begin
      res_q <= neg_q ? -$signed(qtr) : $signed(qtr);
    end
    if (out_load) begin
      oval_q  <= res_q;
      och_q   <= wch_q;
      oorow_q <= orow_q;
      oocol_q <= ocol_q;
      olast_q <= wlast_q;
    end
  end

  p2dma_ring #(
    .DEPTH (DEPTH),
    .SB    (SB)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (accept),
    .wr_addr_i (wr_addr),
    .wr_data_i (sample_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  p2dma_div #(
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign out_valid_o    = ovld_q;
  assign pooled_value_o = oval_q;
  assign out_channel_o  = och_q;
  assign out_row_o      = oorow_q;
  assign out_col_o      = oocol_q;
  assign last_o         = olast_q;

  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o) else $error("loaded beat not presented");

  a_cand_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cand) |=> (state_q == ST_DROW && div_busy))
    else $error("window candidate did not start phase check");

  a_read_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_READ || state_q == ST_DRAIN))
    else $error("ring data returned outside window read");

endmodule

/* src/p2dma_ring.sv */
// ----------------------------------------------------------------------------
// p2dma_ring
// Row ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module p2dma_ring #(
  parameter int DEPTH = p2dma_pkg::DEF_MAX_KERNEL * p2dma_pkg::DEF_MAX_WIDTH,
  parameter int SB    = p2dma_pkg::DEF_SAMPLE_BITS,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [SB-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [SB-1:0] rd_data_o
);

  logic [SB-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

/* src/p2dma_div.sv */
// ----------------------------------------------------------------------------
// p2dma_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module p2dma_div #(
  parameter int DW = p2dma_pkg::DEF_SAMPLE_BITS + p2dma_pkg::DIVISOR_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [DW-1:0]                      dividend_i,
  input  logic [p2dma_pkg::DIVISOR_BITS-1:0] divisor_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [DW-1:0]                      quot_o,
  output logic [p2dma_pkg::DIVISOR_BITS-1:0] rem_o
);

  localparam int DVW = p2dma_pkg::DIVISOR_BITS;
  localparam int CNW = $clog2(DW + 1);

  logic           busy_q, done_q;
  logic [CNW-1:0] cnt_q;
  logic [DW-1:0]  quo_q;
  logic [DVW-1:0] rem_q, dvs_q;
  logic [DVW:0]   trial;
  logic           fits;

  assign trial = {rem_q, quo_q[DW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], fits};
      rem_q <= fits ? DVW'(trial - {1'b0, dvs_q}) : DVW'(trial);
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule
